/* src/assert_macros.svh */
// Assertion macros for the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* src/sef_pkg.sv */
// Shared types and constants of the Sobel edge filter.
`default_nettype none
package sef_pkg;

    localparam int ColW     = 11;
    localparam int RowW     = 12;
    localparam int PixW     = 8;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 12;

    typedef logic [ColW-1:0]     t_col;
    typedef logic [RowW-1:0]     t_row;
    typedef logic [PixW-1:0]     t_pix;
    typedef logic [CfgIdxW-1:0]  t_cfg_idx;
    typedef logic [CfgDataW-1:0] t_cfg_data;

    localparam t_cfg_idx CfgImageWidth   = 2'd0;
    localparam t_cfg_idx CfgImageHeight  = 2'd1;
    localparam t_cfg_idx CfgGradientMode = 2'd2;

    localparam logic ReqPixel = 1'b0;
    localparam logic ReqFlush = 1'b1;

    localparam t_pix LevelBorderMag  = 8'd0;
    localparam t_pix LevelBorderGrad = 8'd128;

endpackage
`default_nettype wire

/* src/sef_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sef_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* src/sobel_edge_filter.sv */
// Top level of the streaming 3x3 Sobel edge filter with line store RAM.
//
//  channel | direction | handshake                  | beat payload
//  --------+-----------+----------------------------+-------------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_req_type, i_red, i_green, i_blue
//  output  | out       | o_out_valid / i_out_ready  | o_level, o_frame_last
//  config  | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One beat is taken per cycle while o_in_ready is high. A result passes the registered line
// store read, one stage for the window sums and the output register, and leaves when the
// output side takes it; the previous beat's write is forwarded to a read of the same column.
// Reset is synchronous and needs no clearing pass; for a frame streamed from its start, line
// store entries read before they are written reach only border results.
// A stall on the output holds each stage only while the stage after it is full.
`default_nettype none
module sobel_edge_filter #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire sef_pkg::t_cfg_idx  i_cfg_index,
    input  wire sef_pkg::t_cfg_data i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_req_type,
    input  wire sef_pkg::t_pix      i_red,
    input  wire sef_pkg::t_pix      i_green,
    input  wire sef_pkg::t_pix      i_blue,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sef_pkg::t_pix           o_level,
    output logic                    o_frame_last
);

    import sef_pkg::*;

    localparam int IdxW = $clog2(MAX_WIDTH);
    localparam logic [ColW-1:0] MaxW = (MAX_WIDTH > 2047) ? 11'd2047 : 11'(MAX_WIDTH);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_WIDTH - 1);
    localparam logic [15:0] Recip255 = 16'd32897;

    // Configuration registers
    t_col r_width;
    t_row r_height;
    logic r_grad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 12'd480;
            r_grad   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgImageWidth:   r_width  <= i_cfg_data[ColW-1:0];
                CfgImageHeight:  r_height <= i_cfg_data[RowW-1:0];
                CfgGradientMode: r_grad   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_col w_eff;
    t_row h_eff;

    always_comb begin
        if (r_width == '0) begin
            w_eff = 11'd1;
        end else if (r_width > MaxW) begin
            w_eff = MaxW;
        end else begin
            w_eff = r_width;
        end
        h_eff = (r_height == '0) ? 12'd1 : r_height;
    end

    // Pipeline handshake
    logic r_v1, r_v2, r_ov;
    logic r_pix1, r_emit1;
    logic s3_free, s2_go, s2_free, s1_go, s1_free, accept;

    assign s3_free    = !r_ov || i_out_ready;
    assign s2_go      = r_v2 && s3_free;
    assign s2_free    = !r_v2 || s2_go;
    assign s1_go      = r_v1 && (!r_emit1 || s2_free);
    assign s1_free    = !r_v1 || s1_go;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && s1_free;

    // Stage 0: position counters, emission decision and gray conversion
    t_col r_in_col, r_out_col;
    t_row r_in_row, r_out_row;
    logic r_frame_done;

    t_col n_in_col, n_out_col, oc_base;
    t_row n_in_row, n_out_row, or_base;
    logic n_frame_done;
    logic is_pix, due_pix, emit0, in_col_end, in_row_end, out_col_end, out_row_end;
    logic last0, border0;
    logic [IdxW-1:0] idx0;
    logic [9:0] rgb_sum;
    logic [19:0] gray_prod;
    t_pix gray0;

    assign is_pix = (i_req_type == ReqPixel);

    always_comb begin
        oc_base     = (is_pix && r_frame_done) ? '0 : r_out_col;
        or_base     = (is_pix && r_frame_done) ? '0 : r_out_row;
        due_pix     = (r_in_row >= 12'd2) || (r_in_row == 12'd1 && r_in_col >= 11'd1);
        emit0       = is_pix ? due_pix : r_frame_done;
        in_col_end  = ({1'b0, r_in_col} + 12'd1) >= {1'b0, w_eff};
        in_row_end  = ({1'b0, r_in_row} + 13'd1) >= {1'b0, h_eff};
        out_col_end = ({1'b0, oc_base} + 12'd1) >= {1'b0, w_eff};
        out_row_end = ({1'b0, or_base} + 13'd1) >= {1'b0, h_eff};
        last0       = out_col_end && out_row_end;
        border0     = (oc_base == '0) || (or_base == '0) || out_col_end || out_row_end;

        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = oc_base;
        n_out_row    = or_base;
        n_frame_done = r_frame_done;

        if (is_pix) begin
            n_frame_done = 1'b0;
            if (in_col_end) begin
                n_in_col = '0;
                if (in_row_end) begin
                    n_in_row     = '0;
                    n_frame_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + 12'd1;
                end
            end else begin
                n_in_col = r_in_col + 11'd1;
            end
        end

        if (emit0) begin
            if (out_col_end) begin
                n_out_col = '0;
                if (out_row_end) begin
                    n_out_row    = '0;
                    n_frame_done = 1'b0;
                end else begin
                    n_out_row = or_base + 12'd1;
                end
            end else begin
                n_out_col = oc_base + 11'd1;
            end
        end
    end

    assign idx0 = (32'(r_in_col) < MAX_WIDTH) ? IdxW'(r_in_col) : LastIdx;

    // Division by three as a reciprocal multiply, exact for sums below 2048.
    assign rgb_sum   = 10'(i_red) + 10'(i_green) + 10'(i_blue);
    assign gray_prod = 20'(rgb_sum) * 20'd683;
    assign gray0     = gray_prod[18:11];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_frame_done <= 1'b0;
        end else if (accept) begin
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_frame_done <= n_frame_done;
        end
    end

    // Stage 1: line store read-modify-write and window shift
    logic r_border1, r_last1, r_fwd_hit;
    t_pix r_gray1;
    logic [IdxW-1:0] r_idx1;
    logic [15:0] r_fwd_data, ram_rdata, rd_pair;
    t_pix col_up, col_lo;
    t_pix r_win [3][3];
    t_pix win_new [3][3];
    logic fwd_hit_n;

    sef_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go && r_pix1),
        .i_waddr (r_idx1),
        .i_wdata ({col_lo, r_gray1}),
        .i_re    (accept && is_pix),
        .i_raddr (idx0),
        .o_rdata (ram_rdata)
    );

    // Each entry holds the upper line in its high byte and the lower line in its low byte.
    assign rd_pair   = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign col_up    = rd_pair[15:8];
    assign col_lo    = rd_pair[7:0];
    assign fwd_hit_n = s1_go && r_pix1 && (r_idx1 == idx0);

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                win_new[r][c] = r_win[r][c];
            end
        end
        if (r_pix1) begin
            for (int r = 0; r < 3; r++) begin
                win_new[r][0] = r_win[r][1];
                win_new[r][1] = r_win[r][2];
            end
            win_new[0][2] = col_up;
            win_new[1][2] = col_lo;
            win_new[2][2] = r_gray1;
        end
    end

    logic [9:0] sx_pos, sx_neg, sy_pos, sy_neg;
    logic signed [10:0] sx1, sy1;

    assign sx_pos = 10'(win_new[2][0]) + {1'b0, win_new[2][1], 1'b0} + 10'(win_new[2][2]);
    assign sx_neg = 10'(win_new[0][0]) + {1'b0, win_new[0][1], 1'b0} + 10'(win_new[0][2]);
    assign sy_pos = 10'(win_new[0][0]) + {1'b0, win_new[1][0], 1'b0} + 10'(win_new[2][0]);
    assign sy_neg = 10'(win_new[0][2]) + {1'b0, win_new[1][2], 1'b0} + 10'(win_new[2][2]);
    assign sx1    = $signed({1'b0, sx_pos}) - $signed({1'b0, sx_neg});
    assign sy1    = $signed({1'b0, sy_pos}) - $signed({1'b0, sy_neg});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else begin
            if (accept) begin
                r_v1 <= is_pix || emit0;
            end else if (s1_go) begin
                r_v1 <= 1'b0;
            end
            if (s1_go && r_pix1) begin
                r_win <= win_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix1     <= is_pix;
            r_emit1    <= emit0;
            r_border1  <= border0;
            r_last1    <= last0;
            r_gray1    <= gray0;
            r_idx1     <= idx0;
            r_fwd_hit  <= fwd_hit_n;
            r_fwd_data <= {col_lo, r_gray1};
        end
    end

    // Stage 2: magnitude or gradient level
    logic signed [10:0] r_sx2, r_sy2;
    logic r_border2, r_last2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s1_go && r_emit1) begin
            r_v2 <= 1'b1;
        end else if (s2_go) begin
            r_v2 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_emit1) begin
            r_sx2     <= sx1;
            r_sy2     <= sy1;
            r_border2 <= r_border1;
            r_last2   <= r_last1;
        end
    end

    logic signed [11:0] s2_sum;
    logic [10:0] s2_abs, mag_sum;
    logic [9:0] abs_x, abs_y;
    logic [26:0] s2_prod;
    logic [8:0] quot;
    logic signed [10:0] grad_val;
    t_pix level2;

    assign s2_sum  = 12'(r_sx2) + 12'(r_sy2);
    assign s2_abs  = s2_sum[11] ? 11'(-s2_sum) : s2_sum[10:0];
    // floor(|sum| * 32 / 255) as a multiply by the reciprocal of 255, exact over this range.
    assign s2_prod = 27'(s2_abs) * 27'(Recip255);
    assign quot    = s2_prod[26:18];
    assign abs_x   = r_sx2[10] ? 10'(-r_sx2) : r_sx2[9:0];
    assign abs_y   = r_sy2[10] ? 10'(-r_sy2) : r_sy2[9:0];
    assign mag_sum = 11'(abs_x) + 11'(abs_y);
    assign grad_val = s2_sum[11] ? (11'sd128 - $signed({2'b0, quot}))
                                 : (11'sd128 + $signed({2'b0, quot}));

    always_comb begin
        if (r_border2) begin
            level2 = r_grad ? LevelBorderGrad : LevelBorderMag;
        end else if (r_grad) begin
            if (grad_val < 0) begin
                level2 = '0;
            end else if (grad_val > 11'sd255) begin
                level2 = 8'd255;
            end else begin
                level2 = grad_val[7:0];
            end
        end else begin
            level2 = (mag_sum > 11'd255) ? 8'd255 : mag_sum[7:0];
        end
    end

    // Stage 3: output register
    t_pix r_level;
    logic r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s2_go) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_level <= level2;
            r_last  <= r_last2;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_level      = r_level;
    assign o_frame_last = r_last;

endmodule
`default_nettype wire

/* src/sef_checker.sv */
// Port-level assertions for the Sobel edge filter and their binding.
`default_nettype none
`include "assert_macros.svh"
module sef_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire sef_pkg::t_pix      o_level,
    input wire logic               o_frame_last
);

    import sef_pkg::*;

    // A waiting result beat keeps its payload.
    `ASSERT_CLK(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_level) && $stable(o_frame_last), "output beat changed while stalled")

    // Reset empties the output register.
    `ASSERT_CLK_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "output valid after reset")

    // With the output side free the input side never stalls.
    `ASSERT_CLK(a_in_free, !o_out_valid || i_out_ready |-> o_in_ready, "input stalled with output free")

    // The last pixel of a frame lies on the border.
    `ASSERT_CLK(a_last_border, o_out_valid && o_frame_last |-> o_level == LevelBorderMag || o_level == LevelBorderGrad, "frame end level is not a border level")

endmodule

bind sobel_edge_filter sef_checker u_sef_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_level      (o_level),
    .o_frame_last (o_frame_last)
);
`default_nettype wire

/* bench/sobel_edge_filter_tb.sv */
// Self-checking testbench for the Sobel edge filter: directed frame, fixed phases, then random frames.
module sobel_edge_filter_tb;
    import sef_pkg::*;

    localparam int MaxWidth     = 1024;
    localparam int IdlePct      = 35;
    localparam int SettleCycles = 10;
    localparam int DrainLimit   = 5000;
    localparam int CycleLimit   = 800000;
    localparam int RandomBeats  = 860;
    localparam int PrintLimit   = 100;

    // Index 3 is not decoded by the block; writes to it must change nothing.
    localparam t_cfg_idx CfgSpare = 2'd3;

    typedef enum int {ShadeNoise, ShadeHard, ShadeSmooth} t_shade;

    typedef struct packed {
        t_pix level;
        logic frame_last;
    } t_edge_result;

    typedef struct packed {
        logic         req;
        t_pix         red;
        t_pix         green;
        t_pix         blue;
        logic         pinned;
        t_edge_result pin;
    } t_stim_row;

    // A 4x4 frame in magnitude mode. Border results are typed in; interior ones
    // come from the predictor. A flush in mid-frame and one after draining give nothing.
    localparam t_stim_row DirectedRows [24] = '{
        '{ReqFlush, 8'hA5, 8'h5A, 8'hFF, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd255, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd255, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd0, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd0, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd255, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd0, 8'd0, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd255, 8'd0, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'h3C, 8'hC3, 8'h00, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd255, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd128, 8'd127, 8'd1, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd1, 8'd254, 8'd128, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd0, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd255, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd0, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd255, 8'd255, 8'd255, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd0, 8'd0, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqPixel, 8'd127, 8'd128, 8'd64, 1'b0, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'd0, 8'd0, 8'd0, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'd255, 8'd255, 8'd255, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'd0, 8'd0, 8'd0, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'd255, 8'd255, 8'd255, 1'b1, '{LevelBorderMag, 1'b0}},
        '{ReqFlush, 8'd0, 8'd0, 8'd0, 1'b1, '{LevelBorderMag, 1'b1}},
        '{ReqFlush, 8'd255, 8'd255, 8'd255, 1'b0, '{LevelBorderMag, 1'b0}}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_cfg_we    = 1'b0;
    t_cfg_idx  i_cfg_index = CfgImageWidth;
    t_cfg_data i_cfg_data  = '0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    logic      i_req_type  = ReqPixel;
    t_pix      i_red       = '0;
    t_pix      i_green     = '0;
    t_pix      i_blue      = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_pix      o_level;
    logic      o_frame_last;

    // Typed-in expectation travelling with the beat, sampled on acceptance.
    logic         pin_armed = 1'b0;
    t_edge_result pin_value = '0;

    bit idling_on   = 1'b1;
    int error_count = 0;
    int beats_sent  = 0;
    int cycle_count = 0;

    t_edge_result expected_levels [$];

    // Predictor state.
    int unsigned     cfg_width    = 640;
    int unsigned     cfg_height   = 480;
    bit              cfg_gradient = 1'b0;
    bit [PixW-1:0]   upper_line [MaxWidth];
    bit [PixW-1:0]   lower_line [MaxWidth];
    bit [PixW-1:0]   gray_window [3][3];
    int unsigned     in_col   = 0;
    int unsigned     in_line  = 0;
    int unsigned     out_col  = 0;
    int unsigned     out_line = 0;
    bit              tail_open = 1'b0;

    sobel_edge_filter #(
        .MAX_WIDTH(MaxWidth)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_level     (o_level),
        .o_frame_last(o_frame_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PrintLimit)
            $display("%0t ERROR %s", $time, msg);
        error_count++;
    endtask

    function automatic void store_setting(input t_cfg_idx idx, input t_cfg_data data);
        case (idx)
            CfgImageWidth:   cfg_width = data[ColW-1:0];
            CfgImageHeight:  cfg_height = data[RowW-1:0];
            CfgGradientMode: cfg_gradient = data[0];
            default: ;
        endcase
    endfunction

    // Transposed kernel indexing: the vertical difference feeds sumX and the
    // horizontal one sumY.
    function automatic t_pix edge_level(input int x, input int y, input int w, input int h);
        int sx, sy, acc, ky, kx, g;
        sx = 0;
        sy = 0;
        if (x < 1 || y < 1 || x + 1 >= w || y + 1 >= h) begin
            acc = cfg_gradient ? int'(LevelBorderGrad) : int'(LevelBorderMag);
        end else begin
            for (ky = 0; ky < 3; ky++) begin
                for (kx = 0; kx < 3; kx++) begin
                    g = int'(gray_window[ky][kx]);
                    sx += g * (ky - 1) * (kx == 1 ? 2 : 1);
                    sy += g * (1 - kx) * (ky == 1 ? 2 : 1);
                end
            end
            if (cfg_gradient)
                acc = 128 + ((sx + sy) * 32) / 255;
            else
                acc = (sx < 0 ? -sx : sx) + (sy < 0 ? -sy : sy);
        end
        if (acc < 0) acc = 0;
        if (acc > 255) acc = 255;
        return t_pix'(acc);
    endfunction

    function automatic t_edge_result take_result(input int unsigned w, input int unsigned h);
        t_edge_result res;
        res.level = edge_level(out_col, out_line, w, h);
        res.frame_last = 1'b0;
        if (out_col + 1 >= w) begin
            out_col = 0;
            if (out_line + 1 >= h) begin
                out_line = 0;
                res.frame_last = 1'b1;
                tail_open = 1'b0;
            end else begin
                out_line++;
            end
        end else begin
            out_col++;
        end
        return res;
    endfunction

    // Advances the predictor by one accepted beat; returns 1 when a result is due.
    function automatic bit advance_filter(input logic req, input t_pix red, input t_pix green,
                                          input t_pix blue, output t_edge_result res);
        int unsigned   w, h, slot;
        int            row;
        bit            due;
        bit [PixW-1:0] gray;
        w = cfg_width == 0 ? 1 : (cfg_width > MaxWidth ? MaxWidth : cfg_width);
        h = cfg_height == 0 ? 1 : cfg_height;
        res = '0;
        if (req == ReqFlush) begin
            if (!tail_open)
                return 1'b0;
            res = take_result(w, h);
            return 1'b1;
        end
        // A pixel arriving with the tail undrained abandons it and opens a new frame.
        if (tail_open) begin
            tail_open = 1'b0;
            out_col = 0;
            out_line = 0;
        end
        gray = PixW'((int'(red) + int'(green) + int'(blue)) / 3);
        slot = in_col < MaxWidth ? in_col : MaxWidth - 1;
        for (row = 0; row < 3; row++) begin
            gray_window[row][0] = gray_window[row][1];
            gray_window[row][1] = gray_window[row][2];
        end
        gray_window[0][2] = upper_line[slot];
        gray_window[1][2] = lower_line[slot];
        gray_window[2][2] = gray;
        upper_line[slot] = lower_line[slot];
        lower_line[slot] = gray;
        due = in_line >= 2 || (in_line == 1 && in_col >= 1);
        if (in_col + 1 >= w) begin
            in_col = 0;
            if (in_line + 1 >= h) begin
                in_line = 0;
                tail_open = 1'b1;
            end else begin
                in_line++;
            end
        end else begin
            in_col++;
        end
        if (due)
            res = take_result(w, h);
        return due;
    endfunction

    task automatic check_result(input t_pix level, input logic last);
        t_edge_result want;
        if (expected_levels.size() == 0) begin
            report_mismatch($sformatf("unexpected result level %0d last %0b", level, last));
        end else begin
            want = expected_levels.pop_front();
            if (level !== want.level)
                report_mismatch($sformatf("level %0d, predicted %0d", level, want.level));
            if (last !== want.frame_last)
                report_mismatch($sformatf("frame_last %0b, predicted %0b", last, want.frame_last));
        end
    endtask

    // Results are checked before the new beat is predicted, so an empty store
    // never races with a push in the same edge.
    always @(posedge i_clk) begin
        t_edge_result res;
        if (i_rst_n) begin
            if (i_cfg_we)
                store_setting(i_cfg_index, i_cfg_data);
            if (o_out_valid && i_out_ready)
                check_result(o_level, o_frame_last);
            if (i_in_valid && o_in_ready) begin
                if (advance_filter(i_req_type, i_red, i_green, i_blue, res))
                    expected_levels.push_back(pin_armed ? pin_value : res);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= !idling_on || ($urandom_range(99) >= IdlePct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("sobel_edge_filter: mismatch");
            $finish;
        end
    end

    task automatic send_beat(input logic req, input t_pix red, input t_pix green,
                             input t_pix blue, input logic pinned, input t_edge_result pin);
        int gap;
        gap = 0;
        while (idling_on && $urandom_range(99) < IdlePct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_red      <= red;
        i_green    <= green;
        i_blue     <= blue;
        pin_armed  <= pinned;
        pin_value  <= pin;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1)
            @(posedge i_clk);
        beats_sent++;
    endtask

    // Holds the sender back until every predicted result has been taken, then
    // lets the pipeline settle so that result-free beats have left it too.
    task automatic pause_until_drained();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_levels.size() != 0 && waited < DrainLimit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SettleCycles) @(posedge i_clk);
        if (expected_levels.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_levels.size()));
            expected_levels.delete();
        end
    endtask

    // Unused upper data bits are filled at random; the block must ignore them.
    task automatic load_settings(input int width, input int height, input bit gradient);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CfgImageWidth;
        i_cfg_data  <= {1'($urandom_range(1)), ColW'(width)};
        @(posedge i_clk);
        i_cfg_index <= CfgImageHeight;
        i_cfg_data  <= t_cfg_data'(height);
        @(posedge i_clk);
        i_cfg_index <= CfgGradientMode;
        i_cfg_data  <= {11'($urandom), gradient};
        @(posedge i_clk);
        i_cfg_index <= CfgSpare;
        i_cfg_data  <= t_cfg_data'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pix pick_channel(input t_shade kind, input int base);
        case (kind)
            ShadeNoise: return t_pix'($urandom_range(255));
            ShadeHard:  return $urandom_range(1) ? 8'hFF : 8'h00;
            default:    return t_pix'(base + $urandom_range(12));
        endcase
    endfunction

    // Streams the rest of a frame and its drain. Now and then a stray flush lands
    // in mid-frame, the drain is cut short, or a flush follows the drain.
    task automatic stream_frame(input int pixels, input int tail);
        t_shade kind;
        int     base, drains, i;
        kind = t_shade'($urandom_range(2));
        base = $urandom_range(240);
        for (i = 0; i < pixels; i++) begin
            if (i > 0 && $urandom_range(24) == 0)
                send_beat(ReqFlush, t_pix'($urandom), t_pix'($urandom), t_pix'($urandom),
                          1'b0, '0);
            send_beat(ReqPixel, pick_channel(kind, base), pick_channel(kind, base),
                      pick_channel(kind, base), 1'b0, '0);
        end
        drains = tail;
        if ($urandom_range(9) == 0)
            drains = $urandom_range(tail - 1);
        else if ($urandom_range(7) == 0)
            drains = tail + 1;
        repeat (drains)
            send_beat(ReqFlush, t_pix'($urandom), t_pix'($urandom), t_pix'($urandom),
                      1'b0, '0);
    endtask

    task automatic run_phase(input int width, input int height, input bit gradient,
                             input int frames);
        int w, h;
        pause_until_drained();
        load_settings(width, height, gradient);
        w = width == 0 ? 1 : (width > MaxWidth ? MaxWidth : width);
        h = height == 0 ? 1 : height;
        repeat (frames)
            stream_frame(w * h, (w * h < w + 1) ? w * h : w + 1);
    endtask

    initial begin
        int first_beat, w_raw, h_raw, i;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_settings(4, 4, 1'b0);
        for (i = 0; i < 24; i++)
            send_beat(DirectedRows[i].req, DirectedRows[i].red, DirectedRows[i].green,
                      DirectedRows[i].blue, DirectedRows[i].pinned, DirectedRows[i].pin);

        run_phase(3, 3, 1'b1, 2);
        // Two larger frames streamed back to back without any idling.
        idling_on = 1'b0;
        run_phase(12, 8, 1'b1, 2);
        idling_on = 1'b1;
        run_phase(0, 6, 1'b0, 1);
        run_phase(7, 0, 1'b1, 2);

        // Shrink the line while the first row is part-way through: the next pixel
        // wraps to row one, leaving three rows of three and a tail of four.
        run_phase(8, 5, 1'b0, 1);
        pause_until_drained();
        repeat (5)
            send_beat(ReqPixel, t_pix'($urandom), t_pix'($urandom), t_pix'($urandom),
                      1'b0, '0);
        pause_until_drained();
        load_settings(3, 4, 1'b1);
        stream_frame(10, 4);

        first_beat = beats_sent;
        while (beats_sent - first_beat < RandomBeats) begin
            w_raw = ($urandom_range(15) == 0) ? 0 : $urandom_range(12, 1);
            h_raw = ($urandom_range(15) == 0) ? 0 : $urandom_range(8, 1);
            run_phase(w_raw, h_raw, $urandom_range(1), $urandom_range(3, 1));
        end

        pause_until_drained();
        if (error_count == 0)
            $display("sobel_edge_filter: match");
        else
            $display("sobel_edge_filter: mismatch");
        $finish;
    end

endmodule
